// ----- rtl/cnal_pkg.sv -----
// Package for the channel number allocator: sizes, action codes, request and
// response payloads, the scan token and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cnal_pkg;

  localparam int NUM_CHANNELS = 30;
  // The pointer runs from 0 to NUM_CHANNELS inclusive.
  localparam int IDX_W        = $clog2(NUM_CHANNELS + 1);
  localparam int ACTION_W     = 2;
  localparam int CHAN_W       = 8;
  localparam int GRANT_W      = 5;

  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLAIM   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [CHAN_W-1:0]   channel;
  } req_t;

  typedef struct packed {
    logic               success;
    logic [GRANT_W-1:0] granted_channel;
  } rsp_t;

  // Scan token handed from cell to cell, one cell per cycle.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             alt;
    logic [IDX_W-1:0] alt_idx;
  } token_t;

  // Write of one used bit, broadcast to all cells.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             val;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/cnal_cell.sv -----
// One allocator cell: holds the used bit of a single channel and passes the
// scan token on to the next cell. Depends on cnal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cnal_cell (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [cnal_pkg::IDX_W-1:0] my_idx,
  input  wire logic [cnal_pkg::IDX_W-1:0] nx,
  input  wire cnal_pkg::token_t        tok_in,
  input  wire cnal_pkg::wr_t           wr,
  output cnal_pkg::token_t             tok_out,
  output logic                         used
);
  import cnal_pkg::*;

  logic   elig_first;
  logic   elig_second;
  logic   take;
  logic   alt_here;
  token_t tok_next;
  logic   used_next;

  always_comb begin
    // Channels at or above the pointer belong to the first pass; those below
    // it, except the reserved one, to the wrap-around pass.
    elig_first  = (my_idx >= nx);
    elig_second = (my_idx != '0) && (my_idx < nx);
    take        = tok_in.valid && !tok_in.hit && elig_first && !used;
    alt_here    = tok_in.valid && !tok_in.alt && elig_second && !used;

    tok_next.valid   = tok_in.valid;
    tok_next.hit     = tok_in.hit | take;
    tok_next.hit_idx = take ? my_idx : tok_in.hit_idx;
    tok_next.alt     = tok_in.alt | alt_here;
    tok_next.alt_idx = alt_here ? my_idx : tok_in.alt_idx;

    used_next = used;
    if (take) begin
      used_next = 1'b1;
    end else if (wr.en && (wr.idx == my_idx)) begin
      used_next = wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used    <= 1'b0;
      tok_out <= '0;
    end else begin
      used    <= used_next;
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cnal_ctrl.sv -----
// Controller of the allocator: request handshake, pointer register, claim and
// release decisions and the response register. Depends on cnal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cnal_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_stall,
  input  wire cnal_pkg::req_t             req,
  output logic                            rsp_valid,
  input  wire logic                       rsp_stall,
  output cnal_pkg::rsp_t                  rsp,
  input  wire logic [cnal_pkg::NUM_CHANNELS-1:0] used_vec,
  output logic [cnal_pkg::IDX_W-1:0]      nx,
  output cnal_pkg::token_t                start_tok,
  input  wire cnal_pkg::token_t           end_tok,
  output cnal_pkg::wr_t                   wr
);
  import cnal_pkg::*;

  state_t           state;
  state_t           state_next;
  req_t             req_q;
  token_t           tok_q;
  logic [IDX_W-1:0] nx_next;
  logic             accept;
  logic             rsp_free;
  logic             finish;
  logic             in_range;
  logic [CHAN_W-1:0] ch_minus;
  logic [IDX_W-1:0] ch_idx;
  logic [IDX_W:0]   grant_sum;
  rsp_t             res;

  assign accept   = req_valid && !req_stall;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign finish   = (state == ST_RESULT) && rsp_free;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req.action == ACT_ALLOC) ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (end_tok.valid) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall       = (state != ST_IDLE);
    start_tok       = '0;
    start_tok.valid = accept && (req.action == ACT_ALLOC);

    in_range  = (req_q.channel >= CHAN_W'(2)) && (req_q.channel <= CHAN_W'(NUM_CHANNELS));
    ch_minus  = req_q.channel - CHAN_W'(1);
    ch_idx    = ch_minus[IDX_W-1:0];
    grant_sum = '0;

    res     = '0;
    nx_next = nx;
    wr      = '0;

    case (req_q.action)
      ACT_ALLOC: begin
        if (tok_q.hit) begin
          grant_sum   = {1'b0, tok_q.hit_idx} + (IDX_W+1)'(1);
          res.success = 1'b1;
        end else if (tok_q.alt) begin
          // Wrap-around pass: the cell was only marked, so claim it here.
          grant_sum   = {1'b0, tok_q.alt_idx} + (IDX_W+1)'(1);
          res.success = 1'b1;
          wr.en       = finish;
          wr.idx      = tok_q.alt_idx;
          wr.val      = 1'b1;
        end
        res.granted_channel = GRANT_W'(grant_sum);
        if (res.success) begin
          nx_next = grant_sum[IDX_W-1:0];
        end
      end
      ACT_CLAIM: begin
        if (in_range && !used_vec[ch_idx]) begin
          res.success = 1'b1;
          wr.en       = finish;
          wr.idx      = ch_idx;
          wr.val      = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (in_range) begin
          res.success = 1'b1;
          wr.en       = finish;
          wr.idx      = ch_idx;
          wr.val      = 1'b0;
        end
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      nx        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        nx        <= nx_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if ((state == ST_SCAN) && end_tok.valid) begin
      tok_q <= end_tok;
    end
    if (finish) begin
      rsp <= res;
    end
  end

  a_end_tok_in_scan: assert property (@(posedge clk) disable iff (rst)
    end_tok.valid |-> (state == ST_SCAN))
    else $error("scan token left the chain outside a scan");

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_RESULT))
    else $error("response raised without a result step");

  a_nx_bound: assert property (@(posedge clk) disable iff (rst)
    nx <= IDX_W'(NUM_CHANNELS))
    else $error("next-fit pointer beyond the last channel");

  a_alloc_success: assert property (@(posedge clk) disable iff (rst)
    (finish && (req_q.action == ACT_ALLOC))
      |=> (rsp.success == ($past(tok_q.hit) || $past(tok_q.alt))))
    else $error("allocate success does not match the scan outcome");

endmodule

`default_nettype wire

// ----- rtl/channel_number_allocator_core.sv -----
// Top level of the channel number allocator: a row of one-bit cells that the
// scan token walks, and the controller. Depends on cnal_pkg, cnal_cell, cnal_ctrl.
// Allocate: the scan token walks the NUM_CHANNELS cell registers, one cell per cycle,
// then the result state writes the response register. Claim and release skip the
// scan. No new request is taken until the result is written to the response register.
// A request is taken while an earlier response still waits in its register.
// Synchronous reset frees every channel and clears the pointer at once.
`timescale 1ns / 1ps
`default_nettype none

module channel_number_allocator_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire cnal_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output cnal_pkg::rsp_t      rsp
);
  import cnal_pkg::*;

  token_t                  chain [NUM_CHANNELS+1];
  logic [NUM_CHANNELS-1:0] used_vec;
  logic [IDX_W-1:0]        nx;
  wr_t                     wr;

  cnal_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .used_vec  (used_vec),
    .nx        (nx),
    .start_tok (chain[0]),
    .end_tok   (chain[NUM_CHANNELS]),
    .wr        (wr)
  );

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_cell
    cnal_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .my_idx  (IDX_W'(i)),
      .nx      (nx),
      .tok_in  (chain[i]),
      .wr      (wr),
      .tok_out (chain[i+1]),
      .used    (used_vec[i])
    );
  end

endmodule

`default_nettype wire
